// ===== hw/rtl/bounding_box_3d_reduce_macros.svh =====
// ----------------------------------------------------------------------------
// Bounding box 3D reduce - assertion macros
// Concurrent assertion wrappers, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDING_BOX_3D_REDUCE_MACROS_SVH
`define BOUNDING_BOX_3D_REDUCE_MACROS_SVH

`ifndef SYNTH
// plain property
`define BB3D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// same-cycle implication
`define BB3D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BB3D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BB3D_ASSERT(lbl, prop, msg)
`define BB3D_ASSERT_IMP(lbl, ante, cons, msg)
`define BB3D_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/bb3d_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3d_pkg
// Widths, axis codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3d_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIAG_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * COORD_BITS;
  localparam int SUM_BITS   = 2 * DIAG_BITS;   // holds three squared extents
  localparam int REM_BITS   = DIAG_BITS + 3;
  localparam int NUM_AXES   = 3;
  localparam int AXIS_BITS  = 2;
  localparam int CNT_BITS   = $clog2(DIAG_BITS + 1);
  localparam int SQ_LAST    = 4;               // extent, square, accumulate pipe

  localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic                 pt_en;     // fold in a point
    logic                 pt_first;  // point opens a new set
    logic [AXIS_BITS-1:0] sel_axis;  // axis for extent / result load
    logic                 ext_en;
    logic                 prod_en;
    logic                 acc_clr;
    logic                 acc_en;
    logic                 rt_init;
    logic                 rt_step;
    logic                 out_load;
  } bb3d_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bb3d_ctrl.sv =====
// ----------------------------------------------------------------------------
// bb3d_ctrl
// Sequencer: point intake, squared-extent sum, square root, result drain.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3d_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_point_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bb3d_pkg::bb3d_cmd_t cmd_o
);
  import bb3d_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SQR, ST_ROOT, ST_OUT} state_e;

  state_e               state_q;
  logic [CNT_BITS-1:0]  cnt_q;
  logic                 have_q;
  logic [AXIS_BITS-1:0] axis_q;
  logic                 out_valid_q;
  logic                 out_take;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.sel_axis = AXIS_X;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.pt_en    = in_valid_i;
        cmd_o.pt_first = !have_q;
      end
      ST_SQR: begin
        cmd_o.sel_axis = cnt_q[AXIS_BITS-1:0];
        cmd_o.ext_en   = (cnt_q < CNT_BITS'(NUM_AXES));
        cmd_o.prod_en  = (cnt_q >= CNT_BITS'(1)) && (cnt_q <= CNT_BITS'(NUM_AXES));
        cmd_o.acc_clr  = (cnt_q == '0);
        cmd_o.acc_en   = (cnt_q >= CNT_BITS'(2));
      end
      ST_ROOT: begin
        cmd_o.rt_init  = (cnt_q == '0);
        cmd_o.rt_step  = (cnt_q != '0);
        cmd_o.out_load = (cnt_q == CNT_BITS'(DIAG_BITS));
      end
      ST_OUT: begin
        cmd_o.sel_axis = axis_q + AXIS_BITS'(1);
        cmd_o.out_load = out_take && (axis_q != AXIS_Z);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      have_q      <= 1'b0;
      axis_q      <= AXIS_X;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            have_q <= !last_point_i;
            if (last_point_i) begin
              state_q <= ST_SQR;
              cnt_q   <= '0;
            end
          end
        end
        ST_SQR: begin
          if (cnt_q == CNT_BITS'(SQ_LAST)) begin
            state_q <= ST_ROOT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CNT_BITS'(1);
          end
        end
        ST_ROOT: begin
          if (cnt_q == CNT_BITS'(DIAG_BITS)) begin
            state_q     <= ST_OUT;
            cnt_q       <= '0;
            axis_q      <= AXIS_X;
            out_valid_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + CNT_BITS'(1);
          end
        end
        ST_OUT: begin
          if (out_take) begin
            if (axis_q == AXIS_Z) begin
              out_valid_q <= 1'b0;
              state_q     <= ST_IDLE;
            end else begin
              axis_q <= axis_q + AXIS_BITS'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bb3d_dp.sv =====
// ----------------------------------------------------------------------------
// bb3d_dp
// Min/max registers, shared squarer, accumulator, bit-pair square root and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3d_dp (
  input  logic                                     clk_i,
  input  bb3d_pkg::bb3d_cmd_t                      cmd_i,
  input  logic signed [bb3d_pkg::COORD_BITS-1:0]   px_i,
  input  logic signed [bb3d_pkg::COORD_BITS-1:0]   py_i,
  input  logic signed [bb3d_pkg::COORD_BITS-1:0]   pz_i,
  output logic        [bb3d_pkg::AXIS_BITS-1:0]    axis_o,
  output logic signed [bb3d_pkg::COORD_BITS-1:0]   axis_min_o,
  output logic signed [bb3d_pkg::COORD_BITS-1:0]   axis_max_o,
  output logic signed [bb3d_pkg::COORD_BITS-1:0]   axis_center_o,
  output logic        [bb3d_pkg::COORD_BITS-1:0]   axis_extent_o,
  output logic        [bb3d_pkg::DIAG_BITS-1:0]    diagonal_o,
  output logic                                     last_result_o
);
  import bb3d_pkg::*;

  logic signed [COORD_BITS-1:0] pt    [NUM_AXES];
  logic signed [COORD_BITS-1:0] min_q [NUM_AXES];
  logic signed [COORD_BITS-1:0] max_q [NUM_AXES];

  logic signed [COORD_BITS-1:0] sel_min, sel_max;
  logic        [COORD_BITS:0]   diff_w, sum_w;

  logic [COORD_BITS-1:0] ext_q;
  logic [PROD_BITS-1:0]  prod_q;
  logic [SUM_BITS-1:0]   acc_q;
  logic [SUM_BITS-1:0]   rad_q;
  logic [REM_BITS-1:0]   rem_q, rem_sh, trial, rem_nx;
  logic [DIAG_BITS-1:0]  root_q, root_nx;
  logic                  ge;

  logic [AXIS_BITS-1:0]  axis_q;
  logic [COORD_BITS-1:0] omin_q, omax_q, octr_q, oext_q;
  logic                  olast_q;

  assign pt[0] = px_i;
  assign pt[1] = py_i;
  assign pt[2] = pz_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (cmd_i.pt_first || (pt[a] < min_q[a])) min_q[a] <= pt[a];
        if (cmd_i.pt_first || (pt[a] > max_q[a])) max_q[a] <= pt[a];
      end
    end
  end

  always_comb begin
    unique case (cmd_i.sel_axis)
      AXIS_X: begin
        sel_min = min_q[0];
        sel_max = max_q[0];
      end
      AXIS_Y: begin
        sel_min = min_q[1];
        sel_max = max_q[1];
      end
      default: begin
        sel_min = min_q[2];
        sel_max = max_q[2];
      end
    endcase
  end

  // 25-bit difference and sum; extent and floor-half both fit 24 bits
  assign diff_w = {sel_max[COORD_BITS-1], sel_max} - {sel_min[COORD_BITS-1], sel_min};
  assign sum_w  = {sel_max[COORD_BITS-1], sel_max} + {sel_min[COORD_BITS-1], sel_min};

  // square root: one result bit per step, two radicand bits in
  assign rem_sh  = {rem_q[REM_BITS-3:0], rad_q[SUM_BITS-1 -: 2]};
  assign trial   = REM_BITS'({root_q, 2'b01});
  assign ge      = (rem_sh >= trial);
  assign rem_nx  = ge ? (rem_sh - trial) : rem_sh;
  assign root_nx = {root_q[DIAG_BITS-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ext_en)  ext_q  <= diff_w[COORD_BITS-1:0];
    if (cmd_i.prod_en) prod_q <= PROD_BITS'(ext_q) * PROD_BITS'(ext_q);
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + SUM_BITS'(prod_q);
    end

    if (cmd_i.rt_init) begin
      rad_q  <= acc_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.rt_step) begin
      rad_q  <= {rad_q[SUM_BITS-3:0], 2'b00};
      rem_q  <= rem_nx;
      root_q <= root_nx;
    end

    if (cmd_i.out_load) begin
      axis_q  <= cmd_i.sel_axis;
      omin_q  <= sel_min;
      omax_q  <= sel_max;
      octr_q  <= sum_w[COORD_BITS:1];
      oext_q  <= diff_w[COORD_BITS-1:0];
      olast_q <= (cmd_i.sel_axis == AXIS_Z);
    end
  end

  assign axis_o        = axis_q;
  assign axis_min_o    = omin_q;
  assign axis_max_o    = omax_q;
  assign axis_center_o = octr_q;
  assign axis_extent_o = oext_q;
  assign diagonal_o    = root_q;
  assign last_result_o = olast_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bounding_box_3d_reduce.sv =====
// ----------------------------------------------------------------------------
// bounding_box_3d_reduce
// Per-axis min/max of a 3D point set with center, extent and box diagonal.
// ----------------------------------------------------------------------------
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   in       | in_valid_i/in_stall_o | px_i py_i pz_i last_point_i
//   out      | out_valid_o/out_stall_i | axis_o axis_min_o axis_max_o
//            |                       | axis_center_o axis_extent_o
//            |                       | diagonal_o last_result_o
//
// Points that are not the last of their set stream at one request per cycle
// while in_stall_o is low. The last point runs the shared 24x24 squarer
// pipe on each extent and the bit-pair square root on the sum, then issues
// three result requests (x, y, z), one per cycle when out_stall_i stays low.
// in_stall_o is high from the last point until the z result is taken.
// Reset is asynchronous, active low, and clears only the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounding_box_3d_reduce_macros.svh"

module bounding_box_3d_reduce (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // point requests
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [bb3d_pkg::COORD_BITS-1:0] px_i,
  input  logic signed [bb3d_pkg::COORD_BITS-1:0] py_i,
  input  logic signed [bb3d_pkg::COORD_BITS-1:0] pz_i,
  input  logic                                   last_point_i,
  // result requests
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic        [bb3d_pkg::AXIS_BITS-1:0]  axis_o,
  output logic signed [bb3d_pkg::COORD_BITS-1:0] axis_min_o,
  output logic signed [bb3d_pkg::COORD_BITS-1:0] axis_max_o,
  output logic signed [bb3d_pkg::COORD_BITS-1:0] axis_center_o,
  output logic        [bb3d_pkg::COORD_BITS-1:0] axis_extent_o,
  output logic        [bb3d_pkg::DIAG_BITS-1:0]  diagonal_o,
  output logic                                   last_result_o
);
  import bb3d_pkg::*;

  bb3d_cmd_t cmd;

  // sequencer: owns the handshakes and the set-open flag
  bb3d_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_point_i (last_point_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd)
  );

  // datapath: bounds, squared-extent sum, square root, result register
  bb3d_dp u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .px_i          (px_i),
    .py_i          (py_i),
    .pz_i          (pz_i),
    .axis_o        (axis_o),
    .axis_min_o    (axis_min_o),
    .axis_max_o    (axis_max_o),
    .axis_center_o (axis_center_o),
    .axis_extent_o (axis_extent_o),
    .diagonal_o    (diagonal_o),
    .last_result_o (last_result_o)
  );

  // no point is taken while results are pending
  `BB3D_ASSERT(a_no_in_during_out, !(in_valid_i && !in_stall_o && out_valid_o), "point taken during results")
  // the last point closes intake for the following cycle
  `BB3D_ASSERT_NXT(a_last_stalls, in_valid_i && !in_stall_o && last_point_i, in_stall_o, "intake open after last point")
  // results walk x, y, z
  `BB3D_ASSERT_NXT(a_axis_steps, out_valid_o && !out_stall_i && !last_result_o, out_valid_o && (axis_o == $past(axis_o) + 2'd1), "result axis did not advance")
  // z result flagged and ends the run
  `BB3D_ASSERT_IMP(a_last_is_z, out_valid_o, last_result_o == (axis_o == AXIS_Z), "last flag off z")
  `BB3D_ASSERT_NXT(a_run_ends, out_valid_o && !out_stall_i && last_result_o, !out_valid_o, "results after z")

endmodule

`default_nettype wire
